@@ rtl/idt_pkg.sv @@
// Shared types, constants and calendar tables for the ISO date text converter.
// No dependencies; idt_char_lane, idt_merge, idt_calc and the top level import this package.
`timescale 1ns / 1ps

package idt_pkg;

  localparam int unsigned NumLanes = 8;

  localparam logic [7:0] TextLen = 8'd10;
  localparam logic [7:0] ChDash  = 8'h2D;
  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChNine  = 8'h39;

  localparam logic [23:0] EpochOffset = 24'd719468;
  localparam logic [12:0] Recip100    = 13'd5243;
  localparam int unsigned Recip100Sh  = 19;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_FORMAT  = 2'd1,
    ST_INVALID = 2'd2
  } status_t;

  typedef struct packed {
    logic       is_digit;
    logic [3:0] value;
  } lane_t;

  typedef struct packed {
    logic        fmt_ok;
    logic        leap;
    logic [13:0] year;
    logic [6:0]  month;
    logic [6:0]  day;
  } parse_t;

  typedef struct packed {
    logic signed [22:0] day_count;
    status_t            status;
  } result_t;

  function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
    logic [4:0] len;
    unique case (m)
      4'd2:                      len = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:   len = 5'd30;
      4'd1, 4'd3, 4'd5, 4'd7,
      4'd8, 4'd10, 4'd12:        len = 5'd31;
      default:                   len = 5'd0;
    endcase
    return len;
  endfunction

  // Days before the first of each month, counting from March.
  function automatic logic [8:0] days_before(input logic [3:0] mp);
    logic [8:0] d;
    unique case (mp)
      4'd0:    d = 9'd0;
      4'd1:    d = 9'd31;
      4'd2:    d = 9'd61;
      4'd3:    d = 9'd92;
      4'd4:    d = 9'd122;
      4'd5:    d = 9'd153;
      4'd6:    d = 9'd184;
      4'd7:    d = 9'd214;
      4'd8:    d = 9'd245;
      4'd9:    d = 9'd275;
      4'd10:   d = 9'd306;
      4'd11:   d = 9'd337;
      default: d = 9'd0;
    endcase
    return d;
  endfunction

endpackage

@@ rtl/idt_in_if.sv @@
// Input channel: one date text field and its length per transfer.
// Standalone interface, no package dependency.
`timescale 1ns / 1ps

interface idt_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_length;
  logic [7:0] char_0;
  logic [7:0] char_1;
  logic [7:0] char_2;
  logic [7:0] char_3;
  logic [7:0] char_4;
  logic [7:0] char_5;
  logic [7:0] char_6;
  logic [7:0] char_7;
  logic [7:0] char_8;
  logic [7:0] char_9;

  modport source(output valid, text_length, char_0, char_1, char_2, char_3, char_4,
                 char_5, char_6, char_7, char_8, char_9, input ready);
  modport sink(input valid, text_length, char_0, char_1, char_2, char_3, char_4,
               char_5, char_6, char_7, char_8, char_9, output ready);
endinterface

@@ rtl/idt_out_if.sv @@
// Output channel: day count and status per transfer.
// Standalone interface, no package dependency.
`timescale 1ns / 1ps

interface idt_out_if;
  logic               valid;
  logic               ready;
  logic signed [22:0] day_count;
  logic [1:0]         status;

  modport source(output valid, day_count, status, input ready);
  modport sink(input valid, day_count, status, output ready);
endinterface

@@ rtl/idt_char_lane.sv @@
// One digit lane: classifies an ASCII byte and extracts its digit value.
// Depends on idt_pkg.
`timescale 1ns / 1ps

module idt_char_lane (
  input  logic [7:0]     ch,
  output idt_pkg::lane_t lane
);
  import idt_pkg::*;

  always_comb begin
    lane.is_digit = (ch >= ChZero) && (ch <= ChNine);
    lane.value    = ch[3:0];
  end

endmodule

@@ rtl/idt_merge.sv @@
// Merge stage: combines lane results into year, month, day, format and leap flags.
// Depends on idt_pkg; fed by the idt_char_lane instances.
`timescale 1ns / 1ps

module idt_merge (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  en,
  input  logic                                  in_valid,
  input  logic [7:0]                            text_length,
  input  logic [7:0]                            dash_a,
  input  logic [7:0]                            dash_b,
  input  idt_pkg::lane_t [idt_pkg::NumLanes-1:0] lanes,
  output logic                                  valid,
  output idt_pkg::parse_t                       parse
);
  import idt_pkg::*;

  logic       all_digits;
  logic [6:0] year_hi;
  logic [6:0] year_lo;
  parse_t     parse_next;

  always_comb begin
    all_digits = 1'b1;
    for (int i = 0; i < NumLanes; i++) begin
      all_digits = all_digits & lanes[i].is_digit;
    end
    year_hi = 7'(lanes[0].value) * 7'd10 + 7'(lanes[1].value);
    year_lo = 7'(lanes[2].value) * 7'd10 + 7'(lanes[3].value);
    parse_next.fmt_ok = all_digits && (text_length == TextLen) &&
                        (dash_a == ChDash) && (dash_b == ChDash);
    parse_next.year   = 14'(year_hi) * 14'd100 + 14'(year_lo);
    parse_next.month  = 7'(lanes[4].value) * 7'd10 + 7'(lanes[5].value);
    parse_next.day    = 7'(lanes[6].value) * 7'd10 + 7'(lanes[7].value);
    // Divisible by 4, and either not a century or a century divisible by 400.
    parse_next.leap   = (year_lo[1:0] == 2'd0) &&
                        ((year_lo != 7'd0) || (year_hi[1:0] == 2'd0));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (en) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      parse <= parse_next;
    end
  end

endmodule

@@ rtl/idt_calc.sv @@
// Calendar check and day count: validates the date, then sums the day number.
// Depends on idt_pkg; fed by idt_merge.
`timescale 1ns / 1ps

module idt_calc (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  logic             in_valid,
  input  idt_pkg::parse_t  parse,
  output logic             valid,
  output idt_pkg::result_t result
);
  import idt_pkg::*;

  // check stage
  logic        chk_valid;
  status_t     chk_status;
  logic [13:0] ya;
  logic [26:0] q_prod;
  logic [8:0]  doy;

  logic        early;
  logic [13:0] ya_next;
  logic [3:0]  mp;
  logic [4:0]  lim;
  logic        date_ok;
  status_t     status_next;
  logic [8:0]  doy_next;

  always_comb begin
    early    = (parse.month <= 7'd2);
    ya_next  = early ? parse.year - 14'd1 : parse.year;
    mp       = early ? 4'(parse.month + 7'd9) : 4'(parse.month - 7'd3);
    lim      = month_len(parse.month[3:0], parse.leap);
    date_ok  = (parse.year != 14'd0) && (parse.month >= 7'd1) && (parse.month <= 7'd12) &&
               (parse.day >= 7'd1) && (parse.day <= 7'(lim));
    doy_next = days_before(mp) + 9'(parse.day) - 9'd1;
    priority if (!parse.fmt_ok) begin
      status_next = ST_FORMAT;
    end else if (!date_ok) begin
      status_next = ST_INVALID;
    end else begin
      status_next = ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      chk_valid <= 1'b0;
    end else if (en) begin
      chk_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      chk_status <= status_next;
      ya         <= ya_next;
      q_prod     <= 27'(ya_next) * 27'(Recip100);
      doy        <= doy_next;
    end
  end

  // sum stage
  logic [6:0]  q100;
  logic [23:0] sum;
  result_t     result_next;

  always_comb begin
    q100 = q_prod[Recip100Sh +: 7];
    sum  = 24'(ya) * 24'd365 + 24'(ya[13:2]) - 24'(q100) + 24'(q100[6:2]) +
           24'(doy) - EpochOffset;
    result_next.status    = chk_status;
    result_next.day_count = (chk_status == ST_OK) ? $signed(sum[22:0]) : 23'sd0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (en) begin
      valid <= chk_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      result <= result_next;
    end
  end

endmodule

@@ rtl/iso_date_text_to_epoch_days.sv @@
// Top level: ISO YYYY-MM-DD text to signed days since 1970-01-01.
// Depends on idt_pkg, idt_in_if, idt_out_if, idt_char_lane, idt_merge, idt_calc.
//
//   channel  modport  payload                          role
//   text     sink     text_length, char_0 .. char_9    date text in
//   result   source   day_count, status                day count out
//
// One transfer in per cycle unless result stalls; each result passes the merge, check and sum registers.
// The pipeline is parse (8 digit lanes plus merge), check, sum; the sum stage
// holds the output register.
// rst clears the stage valid bits only.
// A stall on result freezes all stages; text.ready follows directly.
`timescale 1ns / 1ps

module iso_date_text_to_epoch_days (
  input logic       clk,
  input logic       rst,
  idt_in_if.sink    text,
  idt_out_if.source result
);
  import idt_pkg::*;

  logic [7:0]   lane_ch [NumLanes];
  lane_t [NumLanes-1:0] lanes;
  logic         en;
  logic         merge_valid;
  parse_t       parse;
  logic         res_valid;
  result_t      res;

  assign en         = !res_valid || result.ready;
  assign text.ready = en;

  assign lane_ch[0] = text.char_0;
  assign lane_ch[1] = text.char_1;
  assign lane_ch[2] = text.char_2;
  assign lane_ch[3] = text.char_3;
  assign lane_ch[4] = text.char_5;
  assign lane_ch[5] = text.char_6;
  assign lane_ch[6] = text.char_8;
  assign lane_ch[7] = text.char_9;

  for (genvar g = 0; g < NumLanes; g++) begin : g_lane
    idt_char_lane u_lane (
      .ch   (lane_ch[g]),
      .lane (lanes[g])
    );
  end

  idt_merge u_merge (
    .clk         (clk),
    .rst         (rst),
    .en          (en),
    .in_valid    (text.valid),
    .text_length (text.text_length),
    .dash_a      (text.char_4),
    .dash_b      (text.char_7),
    .lanes       (lanes),
    .valid       (merge_valid),
    .parse       (parse)
  );

  idt_calc u_calc (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (merge_valid),
    .parse    (parse),
    .valid    (res_valid),
    .result   (res)
  );

  assign result.valid     = res_valid;
  assign result.day_count = res.day_count;
  assign result.status    = res.status;

endmodule
